// ===== rtl/prq_pkg.sv =====
// Shared constants and field widths for the priority ready-queue scheduler.
package prq_pkg;

  localparam int NUM_TASKS_DEF  = 8;
  localparam int NUM_LEVELS_DEF = 8;

  localparam int CMD_W  = 1;
  localparam int ID_W   = 3;
  localparam int PRIO_W = 3;
  localparam int MASK_W = 8;

  localparam logic [CMD_W-1:0] CMD_ENQUEUE  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_SCHEDULE = 1'b1;

endpackage

// ===== rtl/prq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module prq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/priority_ready_queue_scheduler_core.sv =====
// Top level: per-level task FIFOs held in RAM, bitmap priority pick, running task.
//
//   channel   ports                                             transfer
//   --------  ------------------------------------------------  ---------------------------
//   input     in_cmd, in_task_id, in_task_priority,             start && !busy
//             in_running_blocked
//   result    out_switched, out_current_task,                   out_valid (one cycle strobe)
//             out_previous_task, out_level_mask
//
// The result strobe (S_FINISH) follows S_IDLE directly for an ignored enqueue or a scheduling
// point without a switch. An enqueue passes S_PUSH_ISSUE, and S_PUSH_WAIT for a non-empty
// level; a switch passes S_POP_WAIT and S_POP_LINK (pop), then the push states for a requeue
// of the old task. busy drops in the cycle after the strobe. The steps follow the registered
// reads of the head/tail and link RAMs: head, then successor, then tail of the requeue level.
// Reset (rst_n low, synchronous) empties all levels; task 0 runs at level 0. No clearing pass.
// The receiver cannot stall: out_valid marks each result for its strobe cycle only.
module priority_ready_queue_scheduler_core #(
  parameter int NUM_TASKS  = prq_pkg::NUM_TASKS_DEF,
  parameter int NUM_LEVELS = prq_pkg::NUM_LEVELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [prq_pkg::CMD_W-1:0]   in_cmd,
  input  logic [prq_pkg::ID_W-1:0]    in_task_id,
  input  logic [prq_pkg::PRIO_W-1:0]  in_task_priority,
  input  logic                        in_running_blocked,
  output logic                        out_valid,
  output logic                        out_switched,
  output logic [prq_pkg::ID_W-1:0]    out_current_task,
  output logic [prq_pkg::ID_W-1:0]    out_previous_task,
  output logic [prq_pkg::MASK_W-1:0]  out_level_mask
);

  import prq_pkg::*;

  localparam int TW  = $clog2(NUM_TASKS);
  localparam int LW  = $clog2(NUM_LEVELS);
  localparam int HTW = 2 * TW;

  typedef enum logic [5:0] {
    S_IDLE       = 6'b000001,
    S_PUSH_ISSUE = 6'b000010,
    S_PUSH_WAIT  = 6'b000100,
    S_POP_WAIT   = 6'b001000,
    S_POP_LINK   = 6'b010000,
    S_FINISH     = 6'b100000
  } state_t;

  state_t                state_r, state_nxt;
  logic [NUM_LEVELS-1:0] bitmap_r, bitmap_nxt;
  logic [NUM_TASKS-1:0]  queued_r, queued_nxt;
  logic [TW-1:0]         active_task_r, active_task_nxt;
  logic [LW-1:0]         active_level_r, active_level_nxt;
  logic [TW-1:0]         prev_r, prev_nxt;
  logic                  switched_r, switched_nxt;
  logic                  blocked_r, blocked_nxt;
  logic [LW-1:0]         top_r, top_nxt;
  logic [TW-1:0]         push_tid_r, push_tid_nxt;
  logic [LW-1:0]         push_lvl_r, push_lvl_nxt;
  logic [TW-1:0]         pop_head_r, pop_head_nxt;
  logic [TW-1:0]         pop_tail_r, pop_tail_nxt;

  // head/tail RAM, one entry per level: {head, tail}
  logic           ht_we;
  logic [LW-1:0]  ht_waddr, ht_raddr;
  logic [HTW-1:0] ht_wdata, ht_rdata;
  logic [TW-1:0]  rd_head, rd_tail;

  // successor link RAM, one entry per task
  logic           lk_we;
  logic [TW-1:0]  lk_waddr, lk_raddr, lk_wdata, lk_rdata;

  logic [LW-1:0]  top;
  logic           have_top;
  logic           take;
  logic           enq_ok;
  logic           prev_queued;
  logic [MASK_W+NUM_LEVELS-1:0] mask_ext;

  prq_ram #(.WIDTH(HTW), .DEPTH(NUM_LEVELS)) u_ht_ram (
    .clk   (clk),
    .we    (ht_we),
    .waddr (ht_waddr),
    .wdata (ht_wdata),
    .raddr (ht_raddr),
    .rdata (ht_rdata)
  );

  prq_ram #(.WIDTH(TW), .DEPTH(NUM_TASKS)) u_link_ram (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .raddr (lk_raddr),
    .rdata (lk_rdata)
  );

  assign rd_head = ht_rdata[HTW-1:TW];
  assign rd_tail = ht_rdata[TW-1:0];

  // leading-one search: highest non-empty level
  always_comb begin
    top      = '0;
    have_top = |bitmap_r;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (bitmap_r[i]) begin
        top = LW'(i);
      end
    end
  end

  assign take   = have_top && (in_running_blocked || (top >= active_level_r));
  assign enq_ok = (32'(in_task_id) < NUM_TASKS) && (32'(in_task_priority) < NUM_LEVELS) &&
                  !queued_r[TW'(in_task_id)];
  // popped head has already left its FIFO, so it no longer counts as queued
  assign prev_queued = queued_r[prev_r] && (prev_r != pop_head_r);

  always_comb begin
    state_nxt        = state_r;
    bitmap_nxt       = bitmap_r;
    queued_nxt       = queued_r;
    active_task_nxt  = active_task_r;
    active_level_nxt = active_level_r;
    prev_nxt         = prev_r;
    switched_nxt     = switched_r;
    blocked_nxt      = blocked_r;
    top_nxt          = top_r;
    push_tid_nxt     = push_tid_r;
    push_lvl_nxt     = push_lvl_r;
    pop_head_nxt     = pop_head_r;
    pop_tail_nxt     = pop_tail_r;
    ht_we            = 1'b0;
    ht_waddr         = push_lvl_r;
    ht_wdata         = {push_tid_r, push_tid_r};
    ht_raddr         = top;
    lk_we            = 1'b0;
    lk_waddr         = rd_tail;
    lk_wdata         = push_tid_r;
    lk_raddr         = rd_head;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          blocked_nxt  = in_running_blocked;
          prev_nxt     = active_task_r;
          switched_nxt = 1'b0;
          if (in_cmd == CMD_ENQUEUE) begin
            if (enq_ok) begin
              push_tid_nxt = TW'(in_task_id);
              push_lvl_nxt = LW'(in_task_priority);
              state_nxt    = S_PUSH_ISSUE;
            end else begin
              state_nxt = S_FINISH;
            end
          end else if (take) begin
            top_nxt   = top;
            state_nxt = S_POP_WAIT;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_PUSH_ISSUE: begin
        ht_raddr = push_lvl_r;
        if (bitmap_r[push_lvl_r]) begin
          state_nxt = S_PUSH_WAIT;
        end else begin
          ht_we                  = 1'b1;
          bitmap_nxt[push_lvl_r] = 1'b1;
          queued_nxt[push_tid_r] = 1'b1;
          state_nxt              = S_FINISH;
        end
      end
      S_PUSH_WAIT: begin
        // append behind the current tail
        lk_we                  = 1'b1;
        ht_we                  = 1'b1;
        ht_wdata               = {rd_head, push_tid_r};
        bitmap_nxt[push_lvl_r] = 1'b1;
        queued_nxt[push_tid_r] = 1'b1;
        state_nxt              = S_FINISH;
      end
      S_POP_WAIT: begin
        pop_head_nxt = rd_head;
        pop_tail_nxt = rd_tail;
        state_nxt    = S_POP_LINK;
      end
      S_POP_LINK: begin
        ht_we    = 1'b1;
        ht_waddr = top_r;
        ht_wdata = {lk_rdata, pop_tail_r};
        if (pop_head_r == pop_tail_r) begin
          bitmap_nxt[top_r] = 1'b0;
        end
        queued_nxt[pop_head_r] = 1'b0;
        active_task_nxt        = pop_head_r;
        active_level_nxt       = top_r;
        switched_nxt           = 1'b1;
        if (!blocked_r && !prev_queued) begin
          push_tid_nxt = prev_r;
          push_lvl_nxt = active_level_r;
          state_nxt    = S_PUSH_ISSUE;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      bitmap_r       <= '0;
      queued_r       <= '0;
      active_task_r  <= '0;
      active_level_r <= '0;
    end else begin
      state_r        <= state_nxt;
      bitmap_r       <= bitmap_nxt;
      queued_r       <= queued_nxt;
      active_task_r  <= active_task_nxt;
      active_level_r <= active_level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r     <= prev_nxt;
    switched_r <= switched_nxt;
    blocked_r  <= blocked_nxt;
    top_r      <= top_nxt;
    push_tid_r <= push_tid_nxt;
    push_lvl_r <= push_lvl_nxt;
    pop_head_r <= pop_head_nxt;
    pop_tail_r <= pop_tail_nxt;
  end

  assign mask_ext = {MASK_W'(0), bitmap_r};

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = (state_r == S_FINISH);
  assign out_switched      = switched_r;
  assign out_current_task  = ID_W'(active_task_r);
  assign out_previous_task = ID_W'(prev_r);
  assign out_level_mask    = mask_ext[MASK_W-1:0];

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("input transfer did not make the block busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  // a task that takes over from another one is not left in any FIFO
  a_running_not_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_switched && (active_task_r != prev_r)) |-> !queued_r[active_task_r])
    else $error("newly running task still marked queued");

  a_levels_have_tasks: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(queued_r) >= $countones(bitmap_r))
    else $error("more non-empty levels than queued tasks");
`endif

endmodule

// ===== tb/tb_priority_ready_queue_scheduler_core.sv =====
// Self-checking testbench for the priority ready-queue scheduler core.
module tb_priority_ready_queue_scheduler_core;
  import prq_pkg::*;

  localparam int N_TASKS        = NUM_TASKS_DEF;
  localparam int N_LEVELS       = NUM_LEVELS_DEF;
  localparam int DIR_ROWS       = 23;
  localparam int RAND_ITEMS     = 1600;
  localparam int QUIET_TAIL     = 200;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic              switched;
    logic [ID_W-1:0]   current;
    logic [ID_W-1:0]   previous;
    logic [MASK_W-1:0] mask;
  } sched_result_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   tid;
    logic [PRIO_W-1:0] prio;
    logic              blk;
    logic              pinned;
    logic              sw;
    logic [ID_W-1:0]   cur;
    logic [ID_W-1:0]   prv;
    logic [MASK_W-1:0] msk;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [CMD_W-1:0]    in_cmd = CMD_ENQUEUE;
  logic [ID_W-1:0]     in_task_id = '0;
  logic [PRIO_W-1:0]   in_task_priority = '0;
  logic                in_running_blocked = 1'b0;
  logic                out_valid;
  logic                out_switched;
  logic [ID_W-1:0]     out_current_task;
  logic [ID_W-1:0]     out_previous_task;
  logic [MASK_W-1:0]   out_level_mask;

  // expectation typed into the table travels with the item
  logic                pin_on = 1'b0;
  sched_result_t       pin_res = '0;

  priority_ready_queue_scheduler_core u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_cmd             (in_cmd),
    .in_task_id         (in_task_id),
    .in_task_priority   (in_task_priority),
    .in_running_blocked (in_running_blocked),
    .out_valid          (out_valid),
    .out_switched       (out_switched),
    .out_current_task   (out_current_task),
    .out_previous_task  (out_previous_task),
    .out_level_mask     (out_level_mask)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // predictor state
  logic [MASK_W-1:0]   ready_mask;
  logic [ID_W-1:0]     lvl_head [N_LEVELS];
  logic [ID_W-1:0]     lvl_tail [N_LEVELS];
  logic [3:0]          lvl_count [N_LEVELS];
  logic [ID_W-1:0]     tsk_next [N_TASKS];
  logic                tsk_queued [N_TASKS];
  logic [ID_W-1:0]     run_task;
  logic [PRIO_W-1:0]   run_level;

  sched_result_t       pending_results [$];
  int                  fault_cnt = 0;
  int                  n_items = 0;
  int                  n_enq = 0;
  int                  n_switch = 0;
  int                  n_blk_switch = 0;
  int                  n_hold = 0;
  int                  stall_cnt = 0;
  bit                  gaps_on = 1'b1;

  function automatic void ready_push(logic [ID_W-1:0] tid, logic [PRIO_W-1:0] lvl);
    if (tsk_queued[tid]) return;
    if (lvl_count[lvl] == 0) begin
      lvl_head[lvl] = tid;
    end else begin
      tsk_next[lvl_tail[lvl]] = tid;
    end
    lvl_tail[lvl] = tid;
    lvl_count[lvl]++;
    tsk_queued[tid] = 1'b1;
    ready_mask[lvl] = 1'b1;
  endfunction

  function automatic logic [ID_W-1:0] ready_pop(logic [PRIO_W-1:0] lvl);
    logic [ID_W-1:0] tid;
    tid = lvl_head[lvl];
    tsk_queued[tid] = 1'b0;
    lvl_head[lvl] = tsk_next[tid];
    if (lvl_count[lvl] != 0) lvl_count[lvl]--;
    if (lvl_count[lvl] == 0) ready_mask[lvl] = 1'b0;
    return tid;
  endfunction

  function automatic sched_result_t schedule_step(logic [CMD_W-1:0] cmd,
                                                  logic [ID_W-1:0] tid,
                                                  logic [PRIO_W-1:0] prio,
                                                  logic blk);
    sched_result_t   r;
    int              top;
    logic [ID_W-1:0] prev;
    logic [ID_W-1:0] nxt;
    prev = run_task;
    r.switched = 1'b0;
    if (cmd == CMD_ENQUEUE) begin
      ready_push(tid, prio);
      n_enq++;
    end else begin
      top = -1;
      for (int l = N_LEVELS - 1; l >= 0; l--)
        if (top < 0 && ready_mask[l]) top = l;
      if (top >= 0 && (blk || top >= int'(run_level))) begin
        nxt = ready_pop(top[PRIO_W-1:0]);
        // a blocked task is dropped; otherwise it goes behind its own level
        if (!blk) ready_push(prev, run_level);
        run_task = nxt;
        run_level = top[PRIO_W-1:0];
        r.switched = 1'b1;
        n_switch++;
        if (blk) n_blk_switch++;
      end else begin
        n_hold++;
      end
    end
    r.current = run_task;
    r.previous = prev;
    r.mask = ready_mask;
    return r;
  endfunction

  always @(posedge clk) begin : result_check
    sched_result_t got;
    sched_result_t want;
    sched_result_t calc;
    if (!rst_n) begin
      ready_mask = '0;
      for (int i = 0; i < N_LEVELS; i++) begin
        lvl_head[i] = '0;
        lvl_tail[i] = '0;
        lvl_count[i] = '0;
      end
      for (int i = 0; i < N_TASKS; i++) begin
        tsk_next[i] = '0;
        tsk_queued[i] = 1'b0;
      end
      run_task = '0;
      run_level = '0;
      pending_results.delete();
    end else begin
      if (out_valid) begin
        got = {out_switched, out_current_task, out_previous_task, out_level_mask};
        if (pending_results.size() == 0) begin
          fault_cnt++;
          if (fault_cnt <= MAX_REPORTS)
            $display("ERROR: unexpected result sw=%0d cur=%0d prev=%0d mask=%02h",
                     got.switched, got.current, got.previous, got.mask);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            fault_cnt++;
            if (fault_cnt <= MAX_REPORTS)
              $display("ERROR: result mismatch sw %0d/%0d cur %0d/%0d prev %0d/%0d mask %02h/%02h (exp/act)",
                       want.switched, got.switched, want.current, got.current,
                       want.previous, got.previous, want.mask, got.mask);
          end
        end
      end
      if (start && !busy) begin
        calc = schedule_step(in_cmd, in_task_id, in_task_priority, in_running_blocked);
        pending_results.push_back(pin_on ? pin_res : calc);
        n_items++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        stall_cnt <= 0;
      end else if (stall_cnt >= WATCHDOG_LIMIT) begin
        $display("ERROR: watchdog expired with %0d results outstanding",
                 pending_results.size());
        $display("Test completed with failures");
        $finish;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
    end
  end

  // directed rows; the last four fields are a typed-in expectation when pinned
  stim_row_t dir_tab [DIR_ROWS] = '{
    // empty bitmap right after reset, plain and blocked, unused fields at zero, then at max
    '{CMD_SCHEDULE, 3'd0, 3'd0, 1'b0, 1'b1, 1'b0, 3'd0, 3'd0, 8'h00},
    '{CMD_SCHEDULE, 3'd7, 3'd7, 1'b1, 1'b1, 1'b0, 3'd0, 3'd0, 8'h00},
    '{CMD_ENQUEUE,  3'd7, 3'd7, 1'b0, 1'b1, 1'b0, 3'd0, 3'd0, 8'h80},
    // duplicate enqueue is dropped
    '{CMD_ENQUEUE,  3'd7, 3'd3, 1'b1, 1'b1, 1'b0, 3'd0, 3'd0, 8'h80},
    // running task itself made ready
    '{CMD_ENQUEUE,  3'd0, 3'd0, 1'b0, 1'b1, 1'b0, 3'd0, 3'd0, 8'h81},
    // old task already queued is not requeued
    '{CMD_SCHEDULE, 3'd0, 3'd0, 1'b0, 1'b1, 1'b1, 3'd7, 3'd0, 8'h01},
    '{CMD_ENQUEUE,  3'd1, 3'd7, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0, 8'h00},
    '{CMD_ENQUEUE,  3'd2, 3'd7, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0, 8'h00},
    // round robin at equal level
    '{CMD_SCHEDULE, 3'd5, 3'd2, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0, 8'h00},
    '{CMD_SCHEDULE, 3'd0, 3'd0, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0, 8'h00},
    '{CMD_ENQUEUE,  3'd3, 3'd2, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0, 8'h00},
    '{CMD_SCHEDULE, 3'd0, 3'd0, 1'b1, 1'b0, 1'b0, 3'd0, 3'd0, 8'h00},
    '{CMD_SCHEDULE, 3'd0, 3'd0, 1'b1, 1'b0, 1'b0, 3'd0, 3'd0, 8'h00},
    // only a lower level waits: no switch unless blocked
    '{CMD_SCHEDULE, 3'd0, 3'd0, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0, 8'h00},
    '{CMD_SCHEDULE, 3'd0, 3'd0, 1'b1, 1'b0, 1'b0, 3'd0, 3'd0, 8'h00},
    '{CMD_ENQUEUE,  3'd4, 3'd0, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0, 8'h00},
    '{CMD_ENQUEUE,  3'd5, 3'd0, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0, 8'h00},
    '{CMD_ENQUEUE,  3'd6, 3'd5, 1'b1, 1'b0, 1'b0, 3'd0, 3'd0, 8'h00},
    '{CMD_SCHEDULE, 3'd0, 3'd0, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0, 8'h00},
    '{CMD_SCHEDULE, 3'd0, 3'd0, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0, 8'h00},
    '{CMD_SCHEDULE, 3'd7, 3'd7, 1'b1, 1'b0, 1'b0, 3'd0, 3'd0, 8'h00},
    '{CMD_SCHEDULE, 3'd0, 3'd0, 1'b1, 1'b0, 1'b0, 3'd0, 3'd0, 8'h00},
    '{CMD_SCHEDULE, 3'd0, 3'd0, 1'b1, 1'b0, 1'b0, 3'd0, 3'd0, 8'h00}
  };

  // called right after the clock rises; returns right after the transfer is taken or after a random idle gap
  task automatic send_item(input stim_row_t r);
    in_cmd             <= r.cmd;
    in_task_id         <= r.tid;
    in_task_priority   <= r.prio;
    in_running_blocked <= r.blk;
    pin_on             <= r.pinned;
    pin_res            <= {r.sw, r.cur, r.prv, r.msk};
    start              <= 1'b1;
    do @(posedge clk); while (busy);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      // sometimes let the gap begin once the block is free
      if ($urandom_range(0, 1) == 1) begin
        do @(posedge clk); while (busy);
      end
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    stim_row_t row;
    int        k;
    int        enq_pct;
    int        blk_pct;
    k = 0;
    enq_pct = 50;
    blk_pct = 30;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) send_item(dir_tab[i]);
    drain_results();

    while (k < RAND_ITEMS) begin
      if (k % 100 == 0) begin
        enq_pct = 30 + 20 * $urandom_range(0, 2);
        blk_pct = 10 + 25 * $urandom_range(0, 2);
        gaps_on = ($urandom_range(0, 2) != 0);
        if (k < RAND_ITEMS - QUIET_TAIL && $urandom_range(0, 3) == 0) drain_results();
      end
      if (k >= RAND_ITEMS - QUIET_TAIL) gaps_on = 1'b0;
      row = '0;
      row.cmd  = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQUEUE : CMD_SCHEDULE;
      row.tid  = ID_W'($urandom_range(0, N_TASKS - 1));
      row.prio = PRIO_W'($urandom_range(0, N_LEVELS - 1));
      row.blk  = ($urandom_range(0, 99) < blk_pct);
      send_item(row);
      k++;
    end

    drain_results();
    repeat (8) @(posedge clk);

    $display("Ran %0d items: %0d enqueues, %0d switches (%0d on a blocked task), %0d held",
             n_items, n_enq, n_switch, n_blk_switch, n_hold);
    $display("Result mismatches or strays: %0d", fault_cnt);
    if (fault_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
